### src/sdpid_pkg.sv
// Shared types and constants of the split-direction PID controller.
package sdpid_pkg;

   localparam int unsigned IntegW = 48;
   localparam int unsigned SumW   = 58;
   localparam int unsigned DivW   = 64;
   localparam int unsigned DivDW  = 32;
   localparam int unsigned CntW   = 7;
   localparam int unsigned RecipSh = 36;

   localparam logic [IntegW-1:0] INTEG_MAX = {IntegW{1'b1}};
   localparam logic [CntW-1:0] DIV_DE_STEPS = 7'd26;
   localparam logic [25:0] MS_PER_S    = 26'd1000;
   // Reciprocal of 1000 scaled by 2^36, exact for dividends below 2^26.
   localparam logic [26:0] RECIP_MS    = 27'd68719477;
   localparam logic [2:0]  DEC_DIGITS  = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_GAIN_P   = 3'd0;
   localparam logic [2:0] REG_GAIN_I   = 3'd1;
   localparam logic [2:0] REG_GAIN_D   = 3'd2;
   localparam logic [2:0] REG_OUT_MIN  = 3'd3;
   localparam logic [2:0] REG_OUT_MAX  = 3'd4;
   localparam logic [2:0] REG_INTERVAL = 3'd5;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [7:0]  output_min;
      logic [7:0]  output_max;
      logic [15:0] min_interval_ms;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_RESET,
      OP_AREA,
      OP_ACCUM,
      OP_DE_START,
      OP_DE_TAKE,
      OP_IMUL_LO,
      OP_IMUL_HI,
      OP_I_START,
      OP_SUM,
      OP_FINISH
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ACCUM,
      ST_DE_START,
      ST_DE_WAIT,
      ST_DE_TAKE,
      ST_IMUL_LO,
      ST_IMUL_HI,
      ST_I_START,
      ST_I_WAIT,
      ST_SUM,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type op;
      logic   rsp_load;
      logic   rsp_updated;
   } cmd_type;

   typedef struct packed {
      logic is_reset;
      logic due;
      logic div_idle;
   } status_type;

endpackage

### src/sdpid_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module sdpid_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sdpid_pkg::DivW-1:0]   dividend,
   input  logic [sdpid_pkg::DivDW-1:0]  divisor,
   input  logic [sdpid_pkg::CntW-1:0]   steps,
   output logic                         idle,
   output logic [sdpid_pkg::DivW-1:0]   quotient
);
   import sdpid_pkg::*;

   logic [DivW-1:0]  num_ff;
   logic [DivDW:0]   rem_ff;
   logic [DivDW-1:0] den_ff;
   logic [CntW-1:0]  cnt_ff;
   logic             busy_ff;
   logic [DivDW:0]   shifted;
   logic [DivDW:0]   diff;
   logic             take;

   // One trial subtraction of the shifted remainder.
   always_comb begin
      shifted = {rem_ff[DivDW-1:0], num_ff[DivW-1]};
      diff    = shifted - {1'b0, den_ff};
      take    = (shifted >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= {num_ff[DivW-2:0], take};
         rem_ff <= take ? diff : shifted;
      end
   end

   assign idle     = !busy_ff;
   assign quotient = num_ff;
endmodule

### src/sdpid_datapath.sv
// Datapath: controller state, arithmetic steps and the response register.
module sdpid_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  sdpid_pkg::cfg_type      cfg,
   input  sdpid_pkg::cmd_type      cmd,
   output sdpid_pkg::status_type   status,
   input  logic                    req_type,
   input  logic signed [15:0]      measured_value,
   input  logic signed [15:0]      target_value,
   input  logic [31:0]             now_ms,
   output logic                    rsp_updated,
   output logic [7:0]              rsp_forward_drive,
   output logic [7:0]              rsp_reverse_drive
);
   import sdpid_pkg::*;

   // Captured request.
   logic              type_ff;
   logic signed [15:0] meas_ff;
   logic signed [15:0] targ_ff;
   logic [31:0]       now_ff;

   // Controller state.
   logic [31:0]       last_ff;
   logic [IntegW-1:0] integ_ff;
   logic [15:0]       prev_ff;
   logic [7:0]        fwd_ff;
   logic [7:0]        rev_ff;

   // Working registers.
   logic [15:0]       e_ff;
   logic [31:0]       dt_ff;
   logic [IntegW-1:0] area_ff;
   logic              de_neg_ff;
   logic signed [26:0] de_ff;
   logic [31:0]       pmul_ff;
   logic [39:0]       ilo_ff;
   logic [63:0]       iprod_ff;
   logic signed [43:0] dmul_ff;
   logic signed [SumW-1:0] s_ff;

   // Division of the integral term by 1000, one 16-bit digit at a time.
   logic [DivW-1:0]   kx_ff;
   logic [DivW-1:0]   kq_ff;
   logic [9:0]        kr_ff;
   logic [15:0]       kd_ff;
   logic [2:0]        kcnt_ff;
   logic              kphase_ff;
   logic              kbusy_ff;
   logic [25:0]       kt;
   logic [52:0]       kprod;
   logic [25:0]       krem;

   logic [31:0]       dt;
   logic signed [16:0] diff;
   logic [16:0]       adiff;
   logic [15:0]       e;
   logic [48:0]       area_prod;
   logic [IntegW:0]   integ_sum;
   logic signed [26:0] ediff;
   logic signed [26:0] enum_prod;
   logic [26:0]       enum_mag;
   logic              div_start;
   logic [DivW-1:0]   div_dividend;
   logic [DivDW-1:0]  div_divisor;
   logic [CntW-1:0]   div_steps;
   logic              div_idle;
   logic [DivW-1:0]   div_q;
   logic signed [SumW-1:0] lo;
   logic signed [SumW-1:0] hi;
   logic [7:0]        drive;

   // Elapsed time, absolute error, trapezoid area, integral sum and the derivative numerator.
   always_comb begin
      dt        = now_ff - last_ff;
      diff      = {targ_ff[15], targ_ff} - {meas_ff[15], meas_ff};
      adiff     = diff[16] ? (17'd0 - diff) : diff;
      e         = adiff[15:0];
      area_prod = ({16'd0, {1'b0, e} + {1'b0, prev_ff}}) * {17'd0, dt};
      integ_sum = {1'b0, integ_ff} + {1'b0, area_ff};
      ediff     = {11'd0, e_ff} - {11'd0, prev_ff};
      enum_prod = ediff * 27'sd1000;
      enum_mag  = enum_prod[26] ? (27'd0 - enum_prod) : enum_prod;
   end

   // Divider request for the derivative.
   always_comb begin
      div_start    = (cmd.op == OP_DE_START);
      div_dividend = {enum_mag[25:0], 38'd0};
      div_divisor  = dt_ff;
      div_steps    = DIV_DE_STEPS;
   end

   sdpid_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .idle     (div_idle),
      .quotient (div_q)
   );

   // Current digit with the running remainder; quotient by reciprocal product.
   always_comb begin
      kt    = {kr_ff, kx_ff[DivW-1:DivW-16]};
      kprod = {27'd0, kt} * {26'd0, RECIP_MS};
      krem  = kt - ({10'd0, kd_ff} * MS_PER_S);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kbusy_ff <= 1'b0;
      end else if (cmd.op == OP_I_START) begin
         kbusy_ff <= 1'b1;
      end else if (kbusy_ff && kphase_ff && (kcnt_ff == 3'd1)) begin
         kbusy_ff <= 1'b0;
      end
   end

   // Digit steps: take the quotient digit, then the remainder and the next digit.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_I_START) begin
         kx_ff     <= iprod_ff;
         kr_ff     <= '0;
         kcnt_ff   <= DEC_DIGITS;
         kphase_ff <= 1'b0;
      end else if (kbusy_ff) begin
         if (!kphase_ff) begin
            kd_ff     <= kprod[RecipSh+15:RecipSh];
            kphase_ff <= 1'b1;
         end else begin
            kr_ff     <= krem[9:0];
            kq_ff     <= {kq_ff[DivW-17:0], kd_ff};
            kx_ff     <= {kx_ff[DivW-17:0], 16'd0};
            kcnt_ff   <= kcnt_ff - 1'b1;
            kphase_ff <= 1'b0;
         end
      end
   end

   // Clamp of the final sum to the output range.
   always_comb begin
      lo = $signed({{(SumW-16){1'b0}}, cfg.output_min, 8'd0});
      hi = $signed({{(SumW-16){1'b0}}, cfg.output_max, 8'd0});
      if (s_ff < lo) begin
         drive = cfg.output_min;
      end else if (s_ff > hi) begin
         drive = cfg.output_max;
      end else begin
         drive = s_ff[15:8];
      end
   end

   assign status.is_reset = type_ff;
   assign status.due      = (dt >= {16'd0, cfg.min_interval_ms});
   assign status.div_idle = div_idle && !kbusy_ff;

   // State that reset clears and that the reset, area, accumulate and finish commands update.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         integ_ff <= '0;
         prev_ff  <= '0;
         fwd_ff   <= '0;
         rev_ff   <= '0;
      end else begin
         case (cmd.op)
            OP_RESET: begin
               last_ff  <= now_ff;
               integ_ff <= '0;
               prev_ff  <= '0;
            end
            OP_AREA: begin
               last_ff <= now_ff;
            end
            OP_ACCUM: begin
               if (area_ff == INTEG_MAX || integ_sum[IntegW]) begin
                  integ_ff <= INTEG_MAX;
               end else begin
                  integ_ff <= integ_sum[IntegW-1:0];
               end
            end
            OP_FINISH: begin
               prev_ff <= e_ff;
               if (targ_ff > meas_ff) begin
                  fwd_ff <= drive;
                  rev_ff <= 8'd0;
               end else if (targ_ff < meas_ff) begin
                  rev_ff <= drive;
                  fwd_ff <= 8'd0;
               end
            end
            default: begin
               last_ff <= last_ff;
            end
         endcase
      end
   end

   // Working registers of the arithmetic sequence.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            type_ff <= req_type;
            meas_ff <= measured_value;
            targ_ff <= target_value;
            now_ff  <= now_ms;
         end
         OP_AREA: begin
            e_ff    <= e;
            dt_ff   <= dt;
            area_ff <= area_prod[48:1];
         end
         OP_DE_START: begin
            de_neg_ff <= enum_prod[26];
         end
         OP_DE_TAKE: begin
            if (dt_ff == 32'd0) begin
               de_ff <= '0;
            end else if (de_neg_ff) begin
               de_ff <= 27'sd0 - $signed({1'b0, div_q[25:0]});
            end else begin
               de_ff <= $signed({1'b0, div_q[25:0]});
            end
            pmul_ff <= {16'd0, cfg.gain_p} * {16'd0, e_ff};
         end
         OP_IMUL_LO: begin
            ilo_ff <= {24'd0, cfg.gain_i} * {16'd0, integ_ff[23:0]};
         end
         OP_IMUL_HI: begin
            iprod_ff <= {({24'd0, cfg.gain_i} * {16'd0, integ_ff[47:24]}), 24'd0}
                      + {24'd0, ilo_ff};
         end
         OP_I_START: begin
            dmul_ff <= $signed({28'd0, cfg.gain_d}) * 44'(de_ff);
         end
         OP_SUM: begin
            s_ff <= $signed({{(SumW-32){1'b0}}, pmul_ff})
                  + $signed({3'd0, kq_ff[54:0]})
                  + SumW'(dmul_ff);
         end
         default: begin
            s_ff <= s_ff;
         end
      endcase
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_updated       <= cmd.rsp_updated;
         rsp_forward_drive <= fwd_ff;
         rsp_reverse_drive <= rev_ff;
      end
   end
endmodule

### src/sdpid_ctrl.sv
// Sequencer of the controller update and the response handshake.
module sdpid_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  sdpid_pkg::status_type  status,
   output sdpid_pkg::cmd_type     cmd
);
   import sdpid_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      upd_ff;
   logic      upd_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      upd_in   = upd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            upd_in = 1'b0;
            if (!status.is_reset && status.due) begin
               state_in = ST_ACCUM;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_ACCUM:    state_in = ST_DE_START;
         ST_DE_START: state_in = ST_DE_WAIT;
         ST_DE_WAIT: begin
            if (status.div_idle) begin
               state_in = ST_DE_TAKE;
            end
         end
         ST_DE_TAKE:  state_in = ST_IMUL_LO;
         ST_IMUL_LO:  state_in = ST_IMUL_HI;
         ST_IMUL_HI:  state_in = ST_I_START;
         ST_I_START:  state_in = ST_I_WAIT;
         ST_I_WAIT: begin
            if (status.div_idle) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:      state_in = ST_FINISH;
         ST_FINISH: begin
            upd_in   = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.op          = OP_NONE;
      cmd.rsp_load    = 1'b0;
      cmd.rsp_updated = upd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_CAPTURE;
            end
         end
         ST_DECIDE: begin
            if (status.is_reset) begin
               cmd.op = OP_RESET;
            end else if (status.due) begin
               cmd.op = OP_AREA;
            end
         end
         ST_ACCUM:    cmd.op = OP_ACCUM;
         ST_DE_START: cmd.op = OP_DE_START;
         ST_DE_TAKE:  cmd.op = OP_DE_TAKE;
         ST_IMUL_LO:  cmd.op = OP_IMUL_LO;
         ST_IMUL_HI:  cmd.op = OP_IMUL_HI;
         ST_I_START:  cmd.op = OP_I_START;
         ST_SUM:      cmd.op = OP_SUM;
         ST_FINISH:   cmd.op = OP_FINISH;
         ST_RESP:     cmd.rsp_load = out_free;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         upd_ff   <= upd_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // A waiting response is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while stalled");

   // The sequence stays in the derivative wait state while the divider runs.
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DE_WAIT && !status.div_idle) |=> (state_ff == ST_DE_WAIT))
      else $error("left divider wait early");

   // A request is taken only by the idle sequencer.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECIDE))
      else $error("accepted request not sequenced");
endmodule

### src/split_direction_pid_controller.sv
// Top level: an update request runs capture, decide, accumulate, the 26-step serial
// divide of the derivative, the integral products, their divide by 1000, sum and
// finish before its response is loaded; a reset request or a sample inside the
// interval goes from decide to the response. One request at a time: the next one
// is accepted the cycle after the response is loaded. Synchronous active-high reset
// clears the state, the integral, the holds and restores the register defaults.
module split_direction_pid_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic signed [15:0] req_measured_value,
   input  logic signed [15:0] req_target_value,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_updated,
   output logic [7:0]         rsp_forward_drive,
   output logic [7:0]         rsp_reverse_drive,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import sdpid_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= 16'd256;
         cfg_ff.gain_i          <= 16'd0;
         cfg_ff.gain_d          <= 16'd0;
         cfg_ff.output_min      <= 8'd0;
         cfg_ff.output_max      <= 8'd255;
         cfg_ff.min_interval_ms <= 16'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GAIN_P:   cfg_ff.gain_p          <= csr_data;
            REG_GAIN_I:   cfg_ff.gain_i          <= csr_data;
            REG_GAIN_D:   cfg_ff.gain_d          <= csr_data;
            REG_OUT_MIN:  cfg_ff.output_min      <= csr_data[7:0];
            REG_OUT_MAX:  cfg_ff.output_max      <= csr_data[7:0];
            REG_INTERVAL: cfg_ff.min_interval_ms <= csr_data;
            default:      cfg_ff <= cfg_ff;
         endcase
      end
   end

   sdpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sdpid_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .measured_value    (req_measured_value),
      .target_value      (req_target_value),
      .now_ms            (req_now_ms),
      .rsp_updated       (rsp_updated),
      .rsp_forward_drive (rsp_forward_drive),
      .rsp_reverse_drive (rsp_reverse_drive)
   );
endmodule
